>>> rtl/pesoh_pkg.sv
// Shared types, codes and field tables for the PES optional header parser.
package pesoh_pkg;

   localparam int unsigned FIELD_COUNT = 12;
   localparam int unsigned VALUE_WIDTH = 42;
   localparam int unsigned SHIFT_WIDTH = 48;

   // Parser position: 0 idle, 1..12 collecting field (code + 1), 13 stuffing
   localparam logic [3:0] POS_IDLE  = 4'd0;
   localparam logic [3:0] POS_STUFF = 4'd13;

   typedef enum logic [3:0] {
      CODE_PTS      = 4'd0,
      CODE_DTS      = 4'd1,
      CODE_ESCR     = 4'd2,
      CODE_ES_RATE  = 4'd3,
      CODE_COPY     = 4'd4,
      CODE_CRC      = 4'd5,
      CODE_EXTFLAGS = 4'd6,
      CODE_PRIV     = 4'd7,
      CODE_PACKLEN  = 4'd8,
      CODE_SEQ      = 4'd9,
      CODE_PSTD     = 4'd10,
      CODE_EXT2     = 4'd11,
      CODE_END      = 4'd12,
      CODE_TRUNC    = 4'd13
   } field_code_type;

   // One result beat handed from the parser core to the output register
   typedef struct packed {
      logic                     valid;
      field_code_type           code;
      logic [VALUE_WIDTH-1:0]   value;
      logic                     header_end;
   } result_type;

   // Field length in bytes, by field code
   function automatic logic [2:0] field_size(input field_code_type code);
      logic [2:0] size;
      unique case (code)
         CODE_PTS, CODE_DTS:                         size = 3'd5;
         CODE_ESCR:                                  size = 3'd6;
         CODE_ES_RATE:                               size = 3'd3;
         CODE_COPY, CODE_EXTFLAGS, CODE_PACKLEN:     size = 3'd1;
         CODE_CRC, CODE_PRIV, CODE_SEQ, CODE_PSTD,
         CODE_EXT2:                                  size = 3'd2;
         default:                                    size = 3'd1;
      endcase
      return size;
   endfunction

   // Map both flag bytes onto one select bit per field, in field order
   function automatic logic [FIELD_COUNT-1:0] field_select(input logic [7:0] main_flags,
                                                           input logic [7:0] ext_flags);
      logic [FIELD_COUNT-1:0] sel;
      sel = {ext_flags[0], ext_flags[4], ext_flags[5], ext_flags[6], ext_flags[7],
             main_flags[0], main_flags[1], main_flags[2], main_flags[4], main_flags[5],
             main_flags[6], main_flags[7]};
      return sel;
   endfunction

   // First selected field at or after index start, as a position; stuffing if none
   function automatic logic [3:0] next_position(input logic [FIELD_COUNT-1:0] sel,
                                                input logic [3:0] start);
      logic [3:0] pos;
      pos = POS_STUFF;
      for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
         if (sel[i] && (4'(i) >= start)) begin
            pos = 4'(i + 1);
         end
      end
      return pos;
   endfunction

endpackage

>>> rtl/pesoh_parser.sv
// Byte-wise PES optional header parser core: field walk state and value decode.
module pesoh_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [7:0]               data_byte,
   input  logic [7:0]               header_flags,
   input  logic                     first_byte,
   input  logic                     last_byte,
   output pesoh_pkg::result_type    result
);

   logic [3:0]                          pos_ff, pos_in;
   logic [2:0]                          count_ff, count_in;
   logic [pesoh_pkg::SHIFT_WIDTH-1:0]   shift_ff, shift_in;
   logic [7:0]                          main_ff, main_in;
   logic [7:0]                          ext_ff, ext_in;

   logic [3:0]                          pos_cur;
   logic [2:0]                          count_cur;
   logic [2:0]                          count_next;
   logic [pesoh_pkg::SHIFT_WIDTH-1:0]   shift_cur;
   logic [pesoh_pkg::SHIFT_WIDTH-1:0]   shift_next;
   logic [7:0]                          ext_cur;
   logic [7:0]                          ext_next;
   logic [3:0]                          pos_after;
   pesoh_pkg::field_code_type           code;
   logic [pesoh_pkg::VALUE_WIDTH-1:0]   value;
   logic [32:0]                         pts;
   logic [32:0]                         escr_base;

   // Apply a first byte: take new flags and restart the walk
   always_comb begin
      main_in   = first_byte ? header_flags : main_ff;
      ext_cur   = first_byte ? 8'd0 : ext_ff;
      count_cur = first_byte ? 3'd0 : count_ff;
      shift_cur = first_byte ? '0 : shift_ff;
      pos_cur   = first_byte ?
                  pesoh_pkg::next_position(pesoh_pkg::field_select(header_flags, 8'd0), 4'd0)
                  : pos_ff;
   end

   // Shift the byte in and count it
   always_comb begin
      code       = pesoh_pkg::field_code_type'(pos_cur - 4'd1);
      shift_next = {shift_cur[pesoh_pkg::SHIFT_WIDTH-9:0], data_byte};
      count_next = count_cur + 3'd1;
      ext_next   = (code == pesoh_pkg::CODE_EXTFLAGS) ? data_byte : ext_cur;
      pos_after  = pesoh_pkg::next_position(pesoh_pkg::field_select(main_in, ext_next),
                                            pos_cur);
   end

   // Decode the completed field value from the shifted bytes
   always_comb begin
      pts       = {shift_next[35:33], shift_next[31:17], shift_next[15:1]};
      escr_base = {shift_next[45:43], shift_next[41:27], shift_next[25:11]};
      case (code)
         pesoh_pkg::CODE_PTS, pesoh_pkg::CODE_DTS:
            value = 42'(pts);
         pesoh_pkg::CODE_ESCR:
            value = 42'(escr_base) * 42'd300 + 42'(shift_next[9:1]);
         pesoh_pkg::CODE_ES_RATE:
            value = 42'(shift_next[22:9]) * 42'd50;
         pesoh_pkg::CODE_COPY:
            value = 42'(shift_next[6:0]);
         pesoh_pkg::CODE_PSTD:
            value = shift_next[13] ? 42'({shift_next[8:0], 10'd0})
                                   : 42'({shift_next[8:0], 7'd0});
         default:
            value = shift_next[pesoh_pkg::VALUE_WIDTH-1:0];
      endcase
   end

   // Advance the walk and form at most one result
   always_comb begin
      pos_in            = pos_cur;
      count_in          = count_cur;
      shift_in          = shift_cur;
      ext_in            = ext_cur;
      result.valid      = 1'b0;
      result.code       = pesoh_pkg::CODE_END;
      result.value      = '0;
      result.header_end = last_byte;
      if (pos_cur == pesoh_pkg::POS_IDLE || pos_cur > pesoh_pkg::POS_STUFF) begin
         // drop bytes outside a header
      end else if (pos_cur == pesoh_pkg::POS_STUFF) begin
         if (last_byte) begin
            pos_in       = pesoh_pkg::POS_IDLE;
            result.valid = 1'b1;
         end
      end else if (count_next < pesoh_pkg::field_size(code)) begin
         count_in = count_next;
         shift_in = shift_next;
         if (last_byte) begin
            pos_in       = pesoh_pkg::POS_IDLE;
            count_in     = 3'd0;
            shift_in     = '0;
            result.valid = 1'b1;
            result.code  = pesoh_pkg::CODE_TRUNC;
         end
      end else begin
         ext_in       = ext_next;
         count_in     = 3'd0;
         shift_in     = '0;
         pos_in       = pos_after;
         result.valid = 1'b1;
         result.code  = code;
         result.value = value;
         if (last_byte) begin
            pos_in = pesoh_pkg::POS_IDLE;
            if (pos_after != pesoh_pkg::POS_STUFF) begin
               result.code  = pesoh_pkg::CODE_TRUNC;
               result.value = '0;
            end
         end
      end
   end

   // Hold parser state; update on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= pesoh_pkg::POS_IDLE;
         count_ff <= 3'd0;
         shift_ff <= '0;
         main_ff  <= 8'd0;
         ext_ff   <= 8'd0;
      end else if (fire) begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         main_ff  <= main_in;
         ext_ff   <= ext_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= pesoh_pkg::POS_STUFF)
      else $error("parser position out of range");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      pos_ff == pesoh_pkg::POS_IDLE |-> count_ff == 3'd0 && shift_ff == '0)
      else $error("idle parser holds partial field");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      fire && last_byte && result.valid |=> pos_ff == pesoh_pkg::POS_IDLE)
      else $error("parser not idle after last header byte");

   a_end_value_zero: assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.code == pesoh_pkg::CODE_END ||
                       result.code == pesoh_pkg::CODE_TRUNC)
      |-> result.value == '0 && result.header_end)
      else $error("end or truncation result malformed");

endmodule

>>> rtl/pes_optional_header_parser_top.sv
// Top level of the PES optional header parser: input register, core, result register.
//
// Takes one header byte per beat and gives at most one result per byte: a
// decoded field (PTS, DTS, ESCR, ES rate, copy info, CRC, extension flags,
// private data, pack length, sequence, P-STD buffer, extension2) on its final
// byte, an end result on a last byte in stuffing, or a truncation result when
// the header stops with a selected field still open. The block accepts one
// byte per clock cycle while the result side is not stalled; a byte's result
// goes from the input register to the result register when the result side
// is not stalled, and a stall holds the byte in the input register until the
// result register drains. The rate is set by the per-byte update of the field
// walk state, which completes combinationally between the input register and
// the result register.
module pes_optional_header_parser_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,   // [7:0] data_byte, [15:8] header_flags
   input  logic          req_tuser,   // [0] first_byte
   input  logic          req_tlast,   // last_byte
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,   // [41:0] field_value, [47:42] zero
   output logic [3:0]    rsp_tuser,   // [3:0] field_code
   output logic          rsp_tlast    // header_end
);

   logic                    in_valid_ff, in_valid_in;
   logic [15:0]             in_data_ff;
   logic                    in_first_ff;
   logic                    in_last_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [3:0]              out_code_ff;
   logic [41:0]             out_value_ff;
   logic                    out_end_ff;
   logic                    proc_fire;
   logic                    req_fire;
   pesoh_pkg::result_type   result;

   // Process the held beat when the result register is free or draining
   assign proc_fire  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_ff);
      if (proc_fire) begin
         out_valid_in = result.valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Hold the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_data_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   pesoh_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (proc_fire),
      .data_byte    (in_data_ff[7:0]),
      .header_flags (in_data_ff[15:8]),
      .first_byte   (in_first_ff),
      .last_byte    (in_last_ff),
      .result       (result)
   );

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (proc_fire && result.valid) begin
         out_code_ff  <= result.code;
         out_value_ff <= result.value;
         out_end_ff   <= result.header_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_value_ff};
   assign rsp_tuser  = out_code_ff;
   assign rsp_tlast  = out_end_ff;

   a_no_result_loss: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !proc_fire)
      else $error("result register overwritten while stalled");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_data_ff))
      else $error("input beat lost before processing");

   a_end_has_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_code_ff == pesoh_pkg::CODE_END ||
                       out_code_ff == pesoh_pkg::CODE_TRUNC) |-> out_end_ff)
      else $error("end or truncation result without header end");

endmodule

>>> bench/tb_pes_optional_header_parser_top.sv
// Self-checking bench for the PES optional header parser: random headers, scoreboard, stalls.
module tb_pes_optional_header_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pesoh_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 300000;
   localparam int unsigned DRAIN_CYCLES    = 16;
   localparam int unsigned ITEMS_PER_PHASE = 450;
   localparam int unsigned PRINT_LIMIT     = 40;
   localparam logic [63:0] ESCR_SCALE      = 64'd300;
   localparam logic [63:0] ES_RATE_UNIT    = 64'd50;
   localparam logic [63:0] PSTD_LARGE      = 64'd1024;
   localparam logic [63:0] PSTD_SMALL      = 64'd128;

   // Expected result of one header byte
   typedef struct packed {
      field_code_type          code;
      logic [VALUE_WIDTH-1:0]  value;
      logic                    hend;
   } field_result_t;

   // Tracks the field walk of the parser and holds the results it must give
   class field_scoreboard;
      logic [3:0]              walk_pos;
      logic [2:0]              byte_count;
      logic [SHIFT_WIDTH-1:0]  shift_reg;
      logic [7:0]              main_sel;
      logic [7:0]              ext_sel;
      field_result_t           expected_fields[$];
      int                      mismatches;

      function new();
         walk_pos   = POS_IDLE;
         byte_count = '0;
         shift_reg  = '0;
         main_sel   = '0;
         ext_sel    = '0;
         mismatches = 0;
      endfunction

      // Flag bit that selects a field, in the main or the extension flags byte
      static function logic [7:0] byte_mask(field_code_type code);
         case (code)
            CODE_PTS:      return 8'h80;
            CODE_DTS:      return 8'h40;
            CODE_ESCR:     return 8'h20;
            CODE_ES_RATE:  return 8'h10;
            CODE_COPY:     return 8'h04;
            CODE_CRC:      return 8'h02;
            CODE_EXTFLAGS: return 8'h01;
            CODE_PRIV:     return 8'h80;
            CODE_PACKLEN:  return 8'h40;
            CODE_SEQ:      return 8'h20;
            CODE_PSTD:     return 8'h10;
            CODE_EXT2:     return 8'h01;
            default:       return 8'h00;
         endcase
      endfunction

      static function int field_length(field_code_type code);
         case (code)
            CODE_PTS, CODE_DTS:                     return 5;
            CODE_ESCR:                              return 6;
            CODE_ES_RATE:                           return 3;
            CODE_COPY, CODE_EXTFLAGS, CODE_PACKLEN: return 1;
            default:                                return 2;
         endcase
      endfunction

      // First selected field at or after index from, as a walk position
      function logic [3:0] next_field(int from);
         logic [7:0] flags;
         for (int i = from; i < FIELD_COUNT; i++) begin
            flags = (i < int'(CODE_PRIV)) ? main_sel : ext_sel;
            if ((flags & byte_mask(field_code_type'(i))) != 8'h00) begin
               return 4'(i + 1);
            end
         end
         return POS_STUFF;
      endfunction

      // Gather a 33-bit time stamp from its three marker-separated pieces
      function logic [63:0] stamp(logic [63:0] w, int hi, int mid, int lo);
         return (((w >> hi) & 64'h7) << 30) | (((w >> mid) & 64'h7fff) << 15) |
                ((w >> lo) & 64'h7fff);
      endfunction

      function logic [VALUE_WIDTH-1:0] decode(field_code_type code, logic [SHIFT_WIDTH-1:0] b);
         logic [63:0] w;
         logic [63:0] acc;
         w = 64'(b);
         case (code)
            CODE_PTS, CODE_DTS: acc = stamp(w, 33, 17, 1);
            CODE_ESCR:          acc = ESCR_SCALE * stamp(w, 43, 27, 11) + ((w >> 1) & 64'h1ff);
            CODE_ES_RATE:       acc = ((w >> 9) & 64'h3fff) * ES_RATE_UNIT;
            CODE_COPY:          acc = w & 64'h7f;
            CODE_PSTD:          acc = (w[13] ? PSTD_LARGE : PSTD_SMALL) * (w & 64'h1ff);
            default:            acc = w;
         endcase
         return acc[VALUE_WIDTH-1:0];
      endfunction

      // Advance the walk by one accepted header byte and queue its result
      function void note_input(logic [7:0] data, logic [7:0] flags, bit first, bit last);
         field_result_t  res;
         field_code_type code;
         if (first) begin
            main_sel   = flags;
            ext_sel    = '0;
            byte_count = '0;
            shift_reg  = '0;
            walk_pos   = next_field(0);
         end
         if (walk_pos == POS_IDLE || walk_pos > POS_STUFF) return;
         res.value = '0;
         res.hend  = 1'b1;
         // stuffing: only a last byte gives a result
         if (walk_pos == POS_STUFF) begin
            if (!last) return;
            walk_pos = POS_IDLE;
            res.code = CODE_END;
            expected_fields.push_back(res);
            return;
         end
         code       = field_code_type'(walk_pos - 4'd1);
         shift_reg  = {shift_reg[SHIFT_WIDTH-9:0], data};
         byte_count = byte_count + 3'd1;
         // field still open
         if (int'(byte_count) < field_length(code)) begin
            if (!last) return;
            walk_pos   = POS_IDLE;
            byte_count = '0;
            shift_reg  = '0;
            res.code   = CODE_TRUNC;
            expected_fields.push_back(res);
            return;
         end
         if (code == CODE_EXTFLAGS) ext_sel = data;
         res.code   = code;
         res.value  = decode(code, shift_reg);
         res.hend   = last;
         walk_pos   = next_field(int'(code) + 1);
         byte_count = '0;
         shift_reg  = '0;
         if (last) begin
            if (walk_pos != POS_STUFF) begin
               res.code  = CODE_TRUNC;
               res.value = '0;
            end
            walk_pos = POS_IDLE;
         end
         expected_fields.push_back(res);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("ERROR: %s", msg);
      endtask

      // Compare one result beat with the oldest pending expectation
      task check_result(logic [3:0] code, logic [47:0] data, logic hend);
         field_result_t want;
         if (expected_fields.size() == 0) begin
            report($sformatf("unexpected result: code %0d value %0h end %0b", code, data, hend));
            return;
         end
         want = expected_fields.pop_front();
         if (code !== want.code)
            report($sformatf("field code %0d, want %0d", code, want.code));
         if (data !== 48'(want.value))
            report($sformatf("code %0d value %0h, want %0h", want.code, data, want.value));
         if (hend !== want.hend)
            report($sformatf("code %0d header end %0b, want %0b", want.code, hend, want.hend));
      endtask

      function int pending();
         return expected_fields.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;   // [7:0] data_byte, [15:8] header_flags
   logic         req_tuser = 1'b0; // [0] first_byte
   logic         req_tlast = 1'b0; // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;        // [41:0] field_value, [47:42] zero
   logic [3:0]   rsp_tuser;        // [3:0] field_code
   logic         rsp_tlast;        // header_end

   field_scoreboard sb = new();
   int unsigned     cycle_count = 0;
   int unsigned     sender_pct = 0;
   int unsigned     receiver_pct = 0;
   int unsigned     items_sent = 0;
   bit              parser_idle = 1'b1;

   pes_optional_header_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_pct);
   end

   // Check every result beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pes_optional_header_parser_top test failed");
         $finish;
      end
   end

   // Offer one header byte, idling first at random, and hold it until taken
   task automatic send_byte(logic [7:0] data, logic [7:0] flags, bit first, bit last,
                            bit counted);
      while ($urandom_range(0, 99) < sender_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {flags, data};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_input(data, flags, first, last);
      if (counted) items_sent++;
   endtask

   // Send a run of header bytes; flags ride on the first, noise on the rest
   task automatic send_sequence(logic [7:0] flags, logic [7:0] seq[$], bit close);
      for (int i = 0; i < seq.size(); i++) begin
         send_byte(seq[i], (i == 0) ? flags : 8'($urandom_range(0, 255)), i == 0,
                   close && (i == seq.size() - 1), 1'b1);
      end
   endtask

   // Build a header from random flags; complete, truncated, restarted or noise
   task automatic send_random_header();
      logic [7:0]     main_f;
      logic [7:0]     ext_f;
      logic [7:0]     seq[$];
      logic [7:0]     mask;
      field_code_type code;
      int             roll;
      int             cut;
      bit             sel;
      main_f = 8'($urandom_range(0, 255));
      ext_f  = 8'($urandom_range(0, 255));
      roll   = $urandom_range(0, 99);
      // stray bytes between headers
      if (roll >= 95 && parser_idle) begin
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                      1'($urandom_range(0, 1)), 1'b0);
         return;
      end
      for (int idx = 0; idx < FIELD_COUNT; idx++) begin
         code = field_code_type'(idx);
         mask = field_scoreboard::byte_mask(code);
         sel  = (idx < int'(CODE_PRIV)) ? ((main_f & mask) != 8'h00)
                                        : (main_f[0] && ((ext_f & mask) != 8'h00));
         if (sel) begin
            repeat (field_scoreboard::field_length(code))
               seq.push_back((code == CODE_EXTFLAGS) ? ext_f : 8'($urandom_range(0, 255)));
         end
      end
      repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom_range(0, 255)));
      if (seq.size() == 0) seq.push_back(8'($urandom_range(0, 255)));
      if (roll < 70 || roll >= 95) begin
         send_sequence(main_f, seq, 1'b1);
         parser_idle = 1'b1;
      end else begin
         cut = $urandom_range(1, seq.size());
         while (seq.size() > cut) void'(seq.pop_back());
         send_sequence(main_f, seq, roll < 85);
         parser_idle = (roll < 85);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // byte while idle, even with last set: ignored
      send_byte(8'hA5, 8'hFF, 1'b0, 1'b1, 1'b0);
      // no fields selected, last on the first byte: end result
      send_sequence(8'h00, '{8'h5A}, 1'b1);
      // PTS of all ones, last on its final byte
      send_sequence(8'h80, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
      // PTS completes but DTS still selected: truncated
      send_sequence(8'hC0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
      // ESCR of all ones then a stuffing last byte
      send_sequence(8'h20, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b1);
      // extension flags select P-STD with the large scale
      send_sequence(8'h01, '{8'h10, 8'h3F, 8'hFF}, 1'b1);
      // ES rate cut off by a new first byte, then copy info
      send_sequence(8'h10, '{8'h12, 8'h34}, 1'b0);
      send_sequence(8'h04, '{8'hFF}, 1'b1);
      parser_idle = 1'b1;

      // random headers under each idling mix
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_pct = 0;  receiver_pct = 0;  end
            1:       begin sender_pct = 76; receiver_pct = 0;  end
            2:       begin sender_pct = 0;  receiver_pct = 76; end
            default: begin sender_pct = 36; receiver_pct = 36; end
         endcase
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) send_random_header();
      end
      req_tvalid <= 1'b0;

      // drain the result side
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("pes_optional_header_parser_top test passed");
      end else begin
         $display("pes_optional_header_parser_top test failed");
      end
      $finish;
   end
endmodule
